[rtl/core/sacfwp_pkg.sv]
// shared constants of the partitioned cache tag store
package sacfwp_pkg;

  localparam int unsigned AddrW    = 40;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned OutWayW  = 4;
  localparam int unsigned QuotaW   = 5;
  localparam int unsigned CfgDataW = 5;
  localparam int unsigned CfgIdxW  = 1;

  // input word: func, line_address, write_flag, core_id, time_stamp
  localparam int unsigned InBits   = 1 + AddrW + 1 + 1 + TimeW;
  localparam int unsigned InDataW  = ((InBits + 7) / 8) * 8;
  // output word: hit, fill_way, evict_valid, evict_dirty, evicted_line_address
  localparam int unsigned OutBits  = 1 + OutWayW + 1 + 1 + AddrW;
  localparam int unsigned OutDataW = ((OutBits + 7) / 8) * 8;

  localparam logic [CfgIdxW-1:0] CfgModeIdx  = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgQuotaIdx = 1'd1;

  localparam logic FuncLookup  = 1'b0;
  localparam logic FuncInstall = 1'b1;

  localparam logic ModeFifo      = 1'b0;
  localparam logic ModePartition = 1'b1;

  localparam logic [QuotaW-1:0] QuotaReset = 5'd4;

endpackage

[rtl/core/set_assoc_cache_fifo_way_partition_top.sv]
// tag store of a two-core set-associative cache with fifo or way-partition replacement
//
// Each word on the slave side is either a lookup or an install. The whole set (all ways
// of tag, owner, dirty, valid and insertion time) sits in one row of a synchronous memory.
// The row is read in the cycle the word is accepted; the compare state then forms the tag
// matches, the core-0 line count and the pairwise age compares of all ways, and the write
// state picks the victim, writes the row back and loads the output register. The next word
// is taken only after the write-back, so a new word is never accepted before the last one
// has been through this read-compare-write loop. The output register lets a new word be
// accepted while a result waits on the master side; the write-back waits only if the
// previous result has not been taken. A lookup hits on a valid way with the same tag owned
// by the requester and marks it dirty on a write. An install fills the lowest invalid way,
// else the oldest line of the set (mode 0) or the oldest line of the core chosen by
// comparing core 0's line count with core0_quota (mode 1), falling back to the oldest line
// of the set when that core owns none. After reset the block clears every row of the
// memory, one row a cycle, before it accepts its first word; configuration writes are
// taken at any time.
module set_assoc_cache_fifo_way_partition_top
  import sacfwp_pkg::*;
#(
  parameter int unsigned SETS = 1024,
  parameter int unsigned WAYS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // config write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // slave side
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // func, line_address, write_flag, core_id, time_stamp (lowest bit first)
  input  logic [InDataW-1:0]  s_axis_tdata,
  // master side
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // hit, fill_way, evict_valid, evict_dirty, evicted_line_address (lowest bit first)
  output logic [OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned SetW   = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned SetLog = $clog2(SETS + 1) - 1;
  localparam int unsigned TagW   = AddrW - SetLog;
  localparam int unsigned WayW   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned CntW   = $clog2(WAYS + 1);
  localparam int unsigned CmpW   = (CntW > QuotaW) ? CntW : QuotaW;

  typedef struct packed {
    logic            valid;
    logic            dirty;
    logic            owner;
    logic [TagW-1:0] tag;
    logic [TimeW-1:0] itime;
  } way_t;

  typedef way_t [WAYS-1:0] row_t;

  typedef enum logic [1:0] {
    StClear,
    StIdle,
    StCompare,
    StWrite
  } state_e;

  // memory holding one set per row
  row_t mem_q [SETS];

  state_e            state_q;
  logic [SetW-1:0]   clr_q;
  logic              mode_q;
  logic [QuotaW-1:0] quota_q;

  // request held for the whole access
  logic              func_q, wr_q, core_q;
  logic [SetW-1:0]   set_q;
  logic [TagW-1:0]   tag_q;
  logic [TimeW-1:0]  ts_q;

  row_t              row_q;
  logic [WAYS-1:0]   match_q;
  logic [CntW-1:0]   cnt0_q;
  logic [WAYS-1:0]   beat_q [WAYS];

  logic              out_valid_q;
  logic [OutDataW-1:0] out_data_q;

  // unpacked input word
  logic              in_func, in_wr, in_core;
  logic [AddrW-1:0]  in_addr;
  logic [TimeW-1:0]  in_ts;

  assign in_func = s_axis_tdata[0];
  assign in_addr = s_axis_tdata[AddrW:1];
  assign in_wr   = s_axis_tdata[AddrW+1];
  assign in_core = s_axis_tdata[AddrW+2];
  assign in_ts   = s_axis_tdata[AddrW+3+:TimeW];

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  logic accept;
  logic out_free;
  assign accept   = s_axis_tvalid & s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  // compare stage: matches, core-0 count and pairwise age order
  logic [WAYS-1:0] match_d;
  logic [CntW-1:0] cnt0_d;
  logic [WAYS-1:0] beat_d [WAYS];

  always_comb begin
    cnt0_d = '0;
    for (int i = 0; i < WAYS; i++) begin
      match_d[i] = row_q[i].valid && (row_q[i].tag == tag_q) && (row_q[i].owner == core_q);
      cnt0_d     = cnt0_d + CntW'(!row_q[i].owner);
      for (int j = 0; j < WAYS; j++) begin
        // way i wins over way j: older, or same age at a lower way
        if (j > i) begin
          beat_d[i][j] = row_q[i].itime <= row_q[j].itime;
        end else begin
          beat_d[i][j] = row_q[i].itime < row_q[j].itime;
        end
      end
    end
  end

  // write stage: victim choice
  logic [WAYS-1:0] inval;
  logic [WAYS-1:0] first_inv;
  logic [WAYS-1:0] core_mask;
  logic [WAYS-1:0] all_mask;
  logic [WAYS-1:0] pick_mask;
  logic [WAYS-1:0] oldest;
  logic [WAYS-1:0] vic_oh;
  logic [WayW-1:0] vic_way;
  logic            sel_core;
  logic [CmpW-1:0] cnt_x, quota_x;
  logic            seen;

  always_comb begin
    cnt_x   = CmpW'(cnt0_q);
    quota_x = CmpW'(quota_q);
    priority if (quota_x > cnt_x) begin
      sel_core = 1'b1;
    end else if (quota_x == cnt_x) begin
      sel_core = core_q;
    end else begin
      sel_core = 1'b0;
    end

    seen = 1'b0;
    for (int i = 0; i < WAYS; i++) begin
      inval[i]     = !row_q[i].valid;
      first_inv[i] = inval[i] && !seen;
      seen         = seen | inval[i];
      all_mask[i]  = row_q[i].valid;
      core_mask[i] = row_q[i].valid && (row_q[i].owner == sel_core);
    end

    if ((mode_q == ModePartition) && (|core_mask)) begin
      pick_mask = core_mask;
    end else begin
      pick_mask = all_mask;
    end

    for (int i = 0; i < WAYS; i++) begin
      oldest[i] = pick_mask[i];
      for (int j = 0; j < WAYS; j++) begin
        if (j != i) begin
          oldest[i] = oldest[i] & (!pick_mask[j] | beat_q[i][j]);
        end
      end
    end

    vic_oh = (|inval) ? first_inv : oldest;

    vic_way = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (vic_oh[i]) begin
        vic_way = vic_way | WayW'(i);
      end
    end
  end

  way_t            vic_e;
  way_t            new_e;
  row_t            row_new;
  logic [AddrW-1:0] ev_addr;
  logic [OutWayW-1:0] vic_out;
  logic [OutDataW-1:0] out_word;

  always_comb begin
    vic_e         = row_q[vic_way];
    new_e.valid   = 1'b1;
    new_e.dirty   = wr_q;
    new_e.owner   = core_q;
    new_e.tag     = tag_q;
    new_e.itime   = ts_q;
    ev_addr       = AddrW'(AddrW'(vic_e.tag) * AddrW'(SETS) + AddrW'(set_q));
    if (WayW >= OutWayW) begin
      vic_out = OutWayW'(vic_way);
    end else begin
      vic_out = OutWayW'(vic_way);
    end

    row_new = row_q;
    out_word = '0;
    if (func_q == FuncLookup) begin
      for (int i = 0; i < WAYS; i++) begin
        if (match_q[i] && wr_q) begin
          row_new[i].dirty = 1'b1;
        end
      end
      out_word[0] = |match_q;
    end else begin
      row_new[vic_way] = new_e;
      out_word[OutWayW:1] = vic_out;
      out_word[OutWayW+1] = vic_e.valid;
      out_word[OutWayW+2] = vic_e.valid & vic_e.dirty;
      out_word[OutWayW+3+:AddrW] = vic_e.valid ? ev_addr : '0;
    end
  end

  // memory: one read and one write port, registered read data
  always_ff @(posedge clk_i) begin
    if (accept) begin
      row_q <= mem_q[SetW'(in_addr % SETS)];
    end
    if (state_q == StClear) begin
      mem_q[clr_q] <= '0;
    end else if ((state_q == StWrite) && out_free) begin
      mem_q[set_q] <= row_new;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= in_func;
      wr_q   <= in_wr;
      core_q <= in_core;
      set_q  <= SetW'(in_addr % SETS);
      tag_q  <= TagW'(in_addr / SETS);
      ts_q   <= in_ts;
    end
    if (state_q == StCompare) begin
      match_q <= match_d;
      cnt0_q  <= cnt0_d;
      beat_q  <= beat_d;
    end
    if ((state_q == StWrite) && out_free) begin
      out_data_q <= out_word;
    end
  end

  // control: state, config registers, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      mode_q      <= ModeFifo;
      quota_q     <= QuotaReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgModeIdx:  mode_q  <= cfg_data_i[0];
          CfgQuotaIdx: quota_q <= cfg_data_i[QuotaW-1:0];
          default: ;
        endcase
      end

      // a new result replaces the one taken in the same cycle
      if ((state_q == StWrite) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        StClear: begin
          if (clr_q == SetW'(SETS - 1)) begin
            state_q <= StIdle;
          end else begin
            clr_q <= clr_q + 1'b1;
          end
        end
        StIdle: begin
          if (accept) begin
            state_q <= StCompare;
          end
        end
        StCompare: begin
          state_q <= StWrite;
        end
        StWrite: begin
          if (out_free) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

[dv/cache_tag_checker.sv]
// checker for the partitioned cache tag store: watches both streams, predicts and compares
module cache_tag_checker
  import sacfwp_pkg::*;
#(
  parameter int unsigned SETS = 1024,
  parameter int unsigned WAYS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [OutDataW-1:0] m_axis_tdata,
  output int                  fail_count,
  output int                  pending_count,
  output int                  lookup_count,
  output int                  hit_count,
  output int                  install_count,
  output int                  evict_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SetW = $clog2(SETS);
  localparam int unsigned TagW = AddrW - SetW;

  // highest field first, so hit lands in bit 0 as on the bus
  typedef struct packed {
    logic [AddrW-1:0]   evicted_addr;
    logic               evict_dirty;
    logic               evict_valid;
    logic [OutWayW-1:0] fill_way;
    logic               hit;
  } cache_result_t;

  bit              ln_valid [SETS*WAYS];
  bit              ln_dirty [SETS*WAYS];
  bit              ln_owner [SETS*WAYS];
  bit [TagW-1:0]   ln_tag   [SETS*WAYS];
  bit [TimeW-1:0]  ln_time  [SETS*WAYS];
  logic            mode_q;
  logic [QuotaW-1:0] quota_q;
  cache_result_t   expected_q[$];

  assign pending_count = expected_q.size();

  task automatic report(input string what, input logic [AddrW-1:0] got,
                        input logic [AddrW-1:0] want);
    $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    fail_count++;
  endtask

  // oldest valid way, restricted to one owner unless any_owner; -1 if none
  function automatic int oldest_of(input int base, input bit any_owner, input bit who);
    int best;
    best = -1;
    for (int w = 0; w < WAYS; w++) begin
      if (ln_valid[base+w] && (any_owner || ln_owner[base+w] == who) &&
          (best < 0 || ln_time[base+w] < ln_time[base+best])) best = w;
    end
    return best;
  endfunction

  function automatic int pick_victim(input int base, input bit core);
    int count0;
    int v;
    bit sel;
    for (int w = 0; w < WAYS; w++) if (!ln_valid[base+w]) return w;
    if (mode_q == ModePartition) begin
      count0 = 0;
      for (int w = 0; w < WAYS; w++) if (!ln_owner[base+w]) count0++;
      if (quota_q > count0) sel = 1'b1;
      else if (quota_q == count0) sel = core;
      else sel = 1'b0;
      v = oldest_of(base, 1'b0, sel);
      if (v >= 0) return v;
    end
    v = oldest_of(base, 1'b1, 1'b0);
    return (v < 0) ? 0 : v;
  endfunction

  function automatic cache_result_t access_line(input logic [InDataW-1:0] d);
    cache_result_t r;
    logic             func;
    logic [AddrW-1:0] addr;
    logic             wr, core;
    logic [TimeW-1:0] ts;
    int               base, v;
    func = d[0];
    addr = d[AddrW:1];
    wr   = d[AddrW+1];
    core = d[AddrW+2];
    ts   = d[AddrW+3 +: TimeW];
    base = int'(addr[SetW-1:0]) * WAYS;
    r = '0;
    if (func == FuncLookup) begin
      lookup_count++;
      for (int w = 0; w < WAYS; w++) begin
        if (ln_valid[base+w] && ln_tag[base+w] == addr[AddrW-1:SetW] &&
            ln_owner[base+w] == core) begin
          r.hit = 1'b1;
          if (wr) ln_dirty[base+w] = 1'b1;
        end
      end
      if (r.hit) hit_count++;
    end else begin
      install_count++;
      v = pick_victim(base, core);
      if (ln_valid[base+v]) begin
        evict_count++;
        r.evict_valid  = 1'b1;
        r.evict_dirty  = ln_dirty[base+v];
        r.evicted_addr = {ln_tag[base+v], addr[SetW-1:0]};
      end
      r.fill_way       = v[OutWayW-1:0];
      ln_valid[base+v] = 1'b1;
      ln_tag[base+v]   = addr[AddrW-1:SetW];
      ln_dirty[base+v] = wr;
      ln_owner[base+v] = core;
      ln_time[base+v]  = ts;
    end
    return r;
  endfunction

  initial begin
    fail_count = 0;
    lookup_count = 0;
    hit_count = 0;
    install_count = 0;
    evict_count = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    cache_result_t got, want;
    if (!rst_ni) begin
      for (int e = 0; e < SETS*WAYS; e++) begin
        ln_valid[e] = 1'b0;
        ln_dirty[e] = 1'b0;
        ln_owner[e] = 1'b0;
      end
      mode_q  = ModeFifo;
      quota_q = QuotaReset;
      expected_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CfgModeIdx) mode_q = cfg_data_i[0];
        else if (cfg_index_i == CfgQuotaIdx) quota_q = cfg_data_i[QuotaW-1:0];
      end
      if (s_axis_tvalid && s_axis_tready) expected_q.push_back(access_line(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[OutBits-1:0];
        if (expected_q.size() == 0) begin
          report("unexpected word", m_axis_tdata[AddrW-1:0], '0);
        end else begin
          want = expected_q.pop_front();
          if (got.hit !== want.hit) report("hit", got.hit, want.hit);
          if (got.fill_way !== want.fill_way)
            report("fill_way", got.fill_way, want.fill_way);
          if (got.evict_valid !== want.evict_valid)
            report("evict_valid", got.evict_valid, want.evict_valid);
          if (got.evict_dirty !== want.evict_dirty)
            report("evict_dirty", got.evict_dirty, want.evict_dirty);
          if (got.evicted_addr !== want.evicted_addr)
            report("evicted_line_address", got.evicted_addr, want.evicted_addr);
        end
      end
    end
  end

endmodule

[dv/testbench.sv]
// stimulus and verdict for the partitioned cache tag store
module testbench;
  import sacfwp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SETS = 1024;
  localparam int unsigned WAYS = 16;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  int fail_count, pending_count, lookup_count, hit_count, install_count, evict_count;

  // receiver hold-off request and stretch without idling
  bit hold_off_req = 1'b0;
  bit steady = 1'b0;
  bit done = 1'b0;
  int words_sent = 0;

  // hot sets and tags keep sets full so eviction and hits happen often
  logic [9:0]  hot_set [6];
  logic [29:0] hot_tag [20];
  logic [31:0] clock_ts = 32'd100;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  set_assoc_cache_fifo_way_partition_top #(.SETS(SETS), .WAYS(WAYS)) u_top (.*);

  cache_tag_checker #(.SETS(SETS), .WAYS(WAYS)) u_checker (.*);

  // short idle lengths mostly, an occasional long one
  function automatic int gap_len();
    if (steady) return 0;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 0;
      5, 6, 7: return $urandom_range(1, 3);
      8: return $urandom_range(4, 10);
      default: return $urandom_range(11, 40);
    endcase
  endfunction

  // drive one word at a falling edge, hold until taken, then idle for a random gap, which may be empty
  task automatic send_word(input logic func, input logic [AddrW-1:0] addr, input logic wr,
                           input logic core, input logic [TimeW-1:0] ts);
    int g;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InDataW-InBits){1'b0}}, ts, core, wr, addr, func};
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
    @(negedge clk_i);
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
  endtask

  // idle until every result is back, then let the pipeline settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending_count != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
  endtask

  // one random access aimed at hot sets and tags, with some noise
  task automatic random_access(input int core_bias);
    logic [9:0]  set_sel;
    logic [29:0] tag_sel;
    logic [31:0] ts;
    logic        core;
    set_sel = ($urandom_range(0, 9) == 0) ? 10'($urandom) : hot_set[$urandom_range(0, 5)];
    tag_sel = ($urandom_range(0, 9) == 0) ? 30'($urandom) : hot_tag[$urandom_range(0, 19)];
    core = ($urandom_range(0, 99) < core_bias) ? 1'b1 : 1'b0;
    clock_ts = clock_ts + $urandom_range(0, 5);
    case ($urandom_range(0, 9))
      0, 1: ts = $urandom_range(0, 3);       // ties on insertion time
      2: ts = $urandom;
      default: ts = clock_ts;
    endcase
    send_word(1'($urandom), {tag_sel, set_sel}, 1'($urandom), core, ts);
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    int g;
    @(negedge clk_i);
    while (!done) begin
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(negedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        g = gap_len();
        if (g > 0) begin
          m_axis_tready <= 1'b0;
          repeat (g) @(negedge clk_i);
        end
        m_axis_tready <= 1'b1;
        @(negedge clk_i);
      end
    end
  end

  initial begin
    logic [4:0] quota_plan [6];
    logic       mode_plan  [6];
    foreach (hot_set[i]) hot_set[i] = 10'($urandom);
    hot_set[0] = '0;
    hot_set[1] = '1;
    foreach (hot_tag[i]) hot_tag[i] = 30'($urandom);
    hot_tag[0] = '0;
    hot_tag[1] = '1;
    mode_plan  = '{ModeFifo, ModePartition, ModePartition, ModePartition, ModeFifo,
                   ModePartition};
    quota_plan = '{5'd4, 5'd0, 5'd16, 5'd4, 5'($urandom_range(0, 16)),
                   5'($urandom_range(1, 15))};

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty lookups, address and time extremes, owner mismatch, a full set
    steady = 1'b1;
    send_word(FuncLookup, '0, 1'b0, 1'b0, '0);
    send_word(FuncLookup, '1, 1'b1, 1'b1, '1);
    send_word(FuncInstall, '1, 1'b0, 1'b1, '1);
    send_word(FuncInstall, '0, 1'b1, 1'b0, '0);
    send_word(FuncLookup, '1, 1'b0, 1'b1, '0);
    send_word(FuncLookup, '1, 1'b0, 1'b0, '0);
    send_word(FuncLookup, '0, 1'b1, 1'b0, '0);
    send_word(FuncInstall, '0, 1'b0, 1'b0, 32'd5);
    for (int i = 0; i < 15; i++)
      send_word(FuncInstall, {30'(i + 1), 10'd7}, 1'(i), 1'(i % 3 == 0), 32'(50 - i));
    send_word(FuncInstall, {30'h3FFFFFFF, 10'd7}, 1'b1, 1'b0, 32'd1000);
    steady = 1'b0;

    for (int p = 0; p < 6; p++) begin
      drain();
      write_cfg(CfgModeIdx, CfgDataW'(mode_plan[p]));
      write_cfg(CfgQuotaIdx, CfgDataW'(quota_plan[p]));
      for (int n = 0; n < 270; n++) begin
        if (p == 1 && n == 40) hold_off_req = 1'b1;
        if (p == 2 && n == 100) drain();
        steady = (n >= 150 && n < 190);
        random_access(p == 2 ? 10 : (p == 3 ? 80 : 50));
      end
    end
    drain();
    repeat (20) @(negedge clk_i);
    done = 1'b1;

    $display("covered %0d words: %0d lookups (%0d hits), %0d installs (%0d evictions)",
             words_sent, lookup_count, hit_count, install_count, evict_count);
    $display("replacement modes fifo and partition, quotas 0, 4, 16 and random");
    if (fail_count == 0 && pending_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout with %0d results outstanding", pending_count);
    $display("testbench NOT OK");
    $finish;
  end

endmodule

[files.f]
rtl/core/sacfwp_pkg.sv
rtl/core/set_assoc_cache_fifo_way_partition_top.sv
dv/cache_tag_checker.sv
dv/testbench.sv
